// ===== rtl/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants for the taylor series unit
// Fixed-point formats, function codes, the per-transaction context that
// travels down the cell chain, and the digit divider geometry.
// ----------------------------------------------------------------------------
package tse_pkg;

  // argument: signed q4.28
  localparam int unsigned X_W         = 32;
  localparam int unsigned X_FRAC      = 28;
  // sum: signed q24.40, term magnitudes are 63 bits
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned MAG_W       = 63;

  // constant divider: dividend split into 16-bit digits, msb first
  localparam int unsigned NUM_W       = 64;
  localparam int unsigned DIGIT_W     = 16;
  localparam int unsigned NUM_DIGITS  = NUM_W / DIGIT_W;
  // remainder holds values below the largest order (2 * MAX_INDEX + 1)
  localparam int unsigned REM_W       = 5;
  localparam int unsigned V_W         = REM_W + DIGIT_W;
  // reciprocal scale, exact for every partial dividend below order * 2^16
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

  // pipeline depth of one cell: multiply, combine, digits, accumulate
  localparam int unsigned CELL_STAGES = NUM_DIGITS + 3;

  localparam int unsigned MAX_INDEX_DEFAULT = 10;

  localparam logic [MAG_W-1:0]        MAG_MAX = {MAG_W{1'b1}};
  localparam logic signed [SUM_W-1:0] ONE_Q40 = 64'sh0000_0100_0000_0000;
  localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  // function selector
  typedef enum logic [1:0] {
    KIND_EXP = 2'd0,
    KIND_SIN = 2'd1,
    KIND_COS = 2'd2
  } kind_t;

  // per-transaction context carried alongside the term
  typedef struct packed {
    kind_t                    kind;
    logic                     xneg;
    logic [X_W-1:0]           ax;
    logic signed [SUM_W-1:0]  sum;
    logic                     ovf;
  } ctx_t;

endpackage

// ===== rtl/taylor_exp_sin_cos.sv =====
// ----------------------------------------------------------------------------
// taylor_exp_sin_cos: pipelined truncated taylor series for e^x, sin, cos
//
//   channel  | handshake       | payload
//   ---------+-----------------+-------------------------------------------
//   command  | start / busy    | x_value (s q4.28), kind (0 exp, 1 sin, 2 cos)
//   result   | done (strobe)   | sum_value (s q24.40), overflow
//
// One transaction is accepted per clock; busy never rises.
// The result leaves a chain of one cell per taylor order, each seven stages
// deep.
// The result is on sum_value/overflow for the single cycle done is high.
// Synchronous reset clears all pipeline valid bits; no clearing pass.
// The receiver cannot stall, so there is no backpressure inside the chain.
// ----------------------------------------------------------------------------
module taylor_exp_sin_cos #(
  parameter int unsigned MAX_INDEX = tse_pkg::MAX_INDEX_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tse_pkg::X_W-1:0]     x_value,
  input  logic [1:0]                         kind,
  output logic                               done,
  output logic signed [tse_pkg::SUM_W-1:0]   sum_value,
  output logic                               overflow
);

  localparam int unsigned NUM_CELLS = 2 * MAX_INDEX + 1;
  localparam int unsigned LATENCY   = tse_pkg::CELL_STAGES * NUM_CELLS;

  logic                        in_valid;
  logic [tse_pkg::X_W-1:0]     x_u;
  tse_pkg::ctx_t               init_ctx;

  logic                        cell_valid [NUM_CELLS+1];
  tse_pkg::ctx_t               cell_ctx   [NUM_CELLS+1];
  logic [tse_pkg::MAG_W-1:0]   cell_mag   [NUM_CELLS+1];

  // command transaction, taken every cycle
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  // sign and magnitude of x, order-zero term of the sum
  always_comb begin
    x_u           = x_value;
    init_ctx.kind = tse_pkg::kind_t'(kind);
    init_ctx.xneg = x_value[tse_pkg::X_W-1];
    init_ctx.ax   = init_ctx.xneg ? (tse_pkg::X_W'(0) - x_u) : x_u;
    init_ctx.ovf  = 1'b0;
    case (init_ctx.kind)
      tse_pkg::KIND_EXP: init_ctx.sum = tse_pkg::ONE_Q40;
      tse_pkg::KIND_COS: init_ctx.sum = tse_pkg::ONE_Q40;
      default:           init_ctx.sum = '0;
    endcase
  end

  assign cell_valid[0] = in_valid;
  assign cell_ctx[0]   = init_ctx;
  assign cell_mag[0]   = tse_pkg::ONE_Q40[tse_pkg::MAG_W-1:0];

  // one cell per order, order k in cell k
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    tse_cell #(
      .K         (c + 1),
      .MAX_INDEX (MAX_INDEX)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[c]),
      .in_ctx    (cell_ctx[c]),
      .in_mag    (cell_mag[c]),
      .out_valid (cell_valid[c+1]),
      .out_ctx   (cell_ctx[c+1]),
      .out_mag   (cell_mag[c+1])
    );
  end

  // result transaction straight from the last cell's registers
  assign done      = cell_valid[NUM_CELLS];
  assign sum_value = cell_ctx[NUM_CELLS].sum;
  assign overflow  = cell_ctx[NUM_CELLS].ovf;

  // every result traces back to a command exactly one latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without matching command");

endmodule

// ===== rtl/tse_digit.sv =====
// ----------------------------------------------------------------------------
// tse_digit: one digit step of division by a constant order
// Folds the running remainder and one 16-bit dividend digit into a quotient
// digit using a scaled reciprocal, then registers quotient and remainder.
// ----------------------------------------------------------------------------
module tse_digit #(
  parameter int unsigned K     = 1,
  parameter int unsigned DIGIT = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  tse_pkg::ctx_t                   in_ctx,
  input  logic [tse_pkg::NUM_W-1:0]       in_num,
  input  logic [tse_pkg::NUM_W-1:0]       in_quo,
  input  logic [tse_pkg::REM_W-1:0]       in_rem,
  output logic                            out_valid,
  output tse_pkg::ctx_t                   out_ctx,
  output logic [tse_pkg::NUM_W-1:0]       out_num,
  output logic [tse_pkg::NUM_W-1:0]       out_quo,
  output logic [tse_pkg::REM_W-1:0]       out_rem
);

  localparam int unsigned PROD_W = tse_pkg::V_W + tse_pkg::RECIP_W;
  localparam logic [tse_pkg::RECIP_W-1:0] RECIP = tse_pkg::RECIP_W'(
    ((64'd1 << tse_pkg::RECIP_SHIFT) + 64'(K) - 64'd1) / 64'(K));
  localparam logic [tse_pkg::REM_W-1:0] KR = tse_pkg::REM_W'(K);

  logic [tse_pkg::V_W-1:0]     v;
  logic [PROD_W-1:0]           prod;
  logic [tse_pkg::DIGIT_W-1:0] qd;
  logic [tse_pkg::V_W-1:0]     back;
  logic [tse_pkg::V_W-1:0]     rem_full;
  logic [tse_pkg::NUM_W-1:0]   quo_next;
  logic [tse_pkg::REM_W-1:0]   rem_next;

  // quotient digit by reciprocal, remainder by back-multiply
  always_comb begin
    v        = {in_rem, in_num[DIGIT*tse_pkg::DIGIT_W +: tse_pkg::DIGIT_W]};
    prod     = PROD_W'(v) * PROD_W'(RECIP);
    qd       = prod[tse_pkg::RECIP_SHIFT +: tse_pkg::DIGIT_W];
    back     = tse_pkg::V_W'(qd) * tse_pkg::V_W'(KR);
    rem_full = v - back;
    rem_next = rem_full[tse_pkg::REM_W-1:0];
    quo_next = in_quo;
    quo_next[DIGIT*tse_pkg::DIGIT_W +: tse_pkg::DIGIT_W] = qd;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    out_ctx <= in_ctx;
    out_num <= in_num;
    out_quo <= quo_next;
    out_rem <= rem_next;
  end

  // remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_rem < KR)
    else $error("digit remainder not below divisor");

endmodule

// ===== rtl/tse_cell.sv =====
// ----------------------------------------------------------------------------
// tse_cell: one taylor order of the chain
// Scales the incoming term magnitude by |x|, divides it by the order with
// rounding, and adds the signed term to the running sum when the order
// belongs to the selected function.
// ----------------------------------------------------------------------------
module tse_cell #(
  parameter int unsigned K         = 1,
  parameter int unsigned MAX_INDEX = tse_pkg::MAX_INDEX_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  tse_pkg::ctx_t               in_ctx,
  input  logic [tse_pkg::MAG_W-1:0]   in_mag,
  output logic                        out_valid,
  output tse_pkg::ctx_t               out_ctx,
  output logic [tse_pkg::MAG_W-1:0]   out_mag
);

  localparam int unsigned FULL_W = 96;
  localparam int unsigned HI_W   = tse_pkg::MAG_W;
  localparam int unsigned RQ_W   = FULL_W - tse_pkg::X_FRAC;
  localparam logic [FULL_W-1:0] ROUND_HALF = FULL_W'(1) << (tse_pkg::X_FRAC - 1);
  localparam logic K_ODD  = 1'(K % 2);
  localparam logic K_BIT1 = 1'((K / 2) % 2);
  localparam logic ACT_EXP = (K <= MAX_INDEX);
  localparam logic ACT_SIN = (K <= 2 * MAX_INDEX + 1);
  localparam logic ACT_COS = (K <= 2 * MAX_INDEX);

  // order takes part in the selected function
  function automatic logic order_active(input tse_pkg::kind_t kd);
    logic act;
    case (kd)
      tse_pkg::KIND_EXP: act = ACT_EXP;
      tse_pkg::KIND_SIN: act = ACT_SIN;
      tse_pkg::KIND_COS: act = ACT_COS;
      default:           act = 1'b0;
    endcase
    return act;
  endfunction

  // order's term enters the sum
  function automatic logic order_used(input tse_pkg::kind_t kd);
    logic u;
    case (kd)
      tse_pkg::KIND_EXP: u = 1'b1;
      tse_pkg::KIND_SIN: u = K_ODD;
      tse_pkg::KIND_COS: u = ~K_ODD;
      default:           u = 1'b0;
    endcase
    return u;
  endfunction

  // stage 1: partial products
  logic                 s1_valid;
  tse_pkg::ctx_t        s1_ctx;
  logic [63:0]          s1_lo;
  logic [HI_W-1:0]      s1_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctx <= in_ctx;
    s1_lo  <= 64'(in_mag[31:0]) * 64'(in_ctx.ax);
    s1_hi  <= HI_W'(in_mag[tse_pkg::MAG_W-1:32]) * HI_W'(in_ctx.ax);
  end

  // stage 2: combine, round, saturate the scaled term
  logic                        s2_valid;
  tse_pkg::ctx_t               s2_ctx;
  logic [tse_pkg::NUM_W-1:0]   s2_num;
  logic [FULL_W-1:0]           full;
  logic [RQ_W-1:0]             rq;
  logic                        mul_ovf;
  tse_pkg::ctx_t               s2_ctx_next;
  logic [tse_pkg::NUM_W-1:0]   s2_num_next;

  always_comb begin
    full    = {1'b0, s1_hi, 32'd0} + FULL_W'(s1_lo) + ROUND_HALF;
    rq      = full[FULL_W-1:tse_pkg::X_FRAC];
    mul_ovf = |rq[RQ_W-1:tse_pkg::MAG_W];
    s2_num_next = {1'b0, mul_ovf ? tse_pkg::MAG_MAX : rq[tse_pkg::MAG_W-1:0]};
    s2_ctx_next = s1_ctx;
    s2_ctx_next.ovf = s1_ctx.ovf | (mul_ovf & order_active(s1_ctx.kind));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctx <= s2_ctx_next;
    s2_num <= s2_num_next;
  end

  // stages 3 and on: digit-serial division by the order, msb digit first
  logic                        dg_valid [tse_pkg::NUM_DIGITS+1];
  tse_pkg::ctx_t               dg_ctx   [tse_pkg::NUM_DIGITS+1];
  logic [tse_pkg::NUM_W-1:0]   dg_num   [tse_pkg::NUM_DIGITS+1];
  logic [tse_pkg::NUM_W-1:0]   dg_quo   [tse_pkg::NUM_DIGITS+1];
  logic [tse_pkg::REM_W-1:0]   dg_rem   [tse_pkg::NUM_DIGITS+1];

  assign dg_valid[0] = s2_valid;
  assign dg_ctx[0]   = s2_ctx;
  assign dg_num[0]   = s2_num;
  assign dg_quo[0]   = '0;
  assign dg_rem[0]   = '0;

  for (genvar i = 0; i < tse_pkg::NUM_DIGITS; i++) begin : g_digit
    tse_digit #(
      .K     (K),
      .DIGIT (tse_pkg::NUM_DIGITS - 1 - i)
    ) u_digit (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dg_valid[i]),
      .in_ctx    (dg_ctx[i]),
      .in_num    (dg_num[i]),
      .in_quo    (dg_quo[i]),
      .in_rem    (dg_rem[i]),
      .out_valid (dg_valid[i+1]),
      .out_ctx   (dg_ctx[i+1]),
      .out_num   (dg_num[i+1]),
      .out_quo   (dg_quo[i+1]),
      .out_rem   (dg_rem[i+1])
    );
  end

  // last stage: round the quotient, add the signed term with saturation
  tse_pkg::ctx_t               d_ctx;
  logic [tse_pkg::MAG_W-1:0]   q;
  logic                        rnd;
  logic                        neg;
  logic                        acc_active;
  logic                        acc_use;
  logic [tse_pkg::SUM_W:0]     addend;
  logic                        cin;
  logic [tse_pkg::SUM_W:0]     total;
  logic [tse_pkg::MAG_W-1:0]   mag_next;
  tse_pkg::ctx_t               ctx_next;

  assign d_ctx = dg_ctx[tse_pkg::NUM_DIGITS];

  always_comb begin
    q          = dg_quo[tse_pkg::NUM_DIGITS][tse_pkg::MAG_W-1:0];
    rnd        = ({dg_rem[tse_pkg::NUM_DIGITS], 1'b0} >= (tse_pkg::REM_W+1)'(K));
    mag_next   = q + tse_pkg::MAG_W'(rnd);
    neg        = (d_ctx.xneg & K_ODD) ^ ((d_ctx.kind != tse_pkg::KIND_EXP) & K_BIT1);
    acc_active = order_active(d_ctx.kind);
    acc_use    = order_used(d_ctx.kind);
    // negate as ~q plus (1 - rnd) so one adder serves both signs
    addend     = neg ? ~{2'b00, q} : {2'b00, q};
    cin        = neg ? ~rnd : rnd;
    total      = {d_ctx.sum[tse_pkg::SUM_W-1], d_ctx.sum} + addend
               + (tse_pkg::SUM_W+1)'(cin);
    ctx_next   = d_ctx;
    if (acc_active && acc_use) begin
      if (total[tse_pkg::SUM_W] != total[tse_pkg::SUM_W-1]) begin
        ctx_next.sum = total[tse_pkg::SUM_W] ? tse_pkg::SUM_MIN : tse_pkg::SUM_MAX;
        ctx_next.ovf = 1'b1;
      end else begin
        ctx_next.sum = total[tse_pkg::SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dg_valid[tse_pkg::NUM_DIGITS];
    end
  end

  always_ff @(posedge clk) begin
    out_ctx <= ctx_next;
    out_mag <= mag_next;
  end

  // overflow, once raised, survives the combine stage
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_ctx.ovf |=> s2_valid && s2_ctx.ovf)
    else $error("overflow flag lost in combine stage");

  // an order outside the selected function leaves the sum alone
  a_idle_order: assert property (@(posedge clk) disable iff (rst)
    dg_valid[tse_pkg::NUM_DIGITS] && !acc_active
      |=> out_valid && out_ctx.sum == $past(d_ctx.sum))
    else $error("inactive order changed the sum");

endmodule
